>>> hdl/slot_free_list_allocator_top_macros.svh
// ----------------------------------------------------------------------------
// slot free list allocator assertion macros
// shared concurrent assertion forms, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef SLOT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH
`define SLOT_FREE_LIST_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define SFLA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sfla assertion failed");

// next-cycle implication
`define SFLA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sfla assertion failed");

// delayed implication
`define SFLA_ASSERT_LAT2(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
    else $error("sfla assertion failed");

`endif

>>> hdl/sfla_pkg.sv
// ----------------------------------------------------------------------------
// sfla_pkg
// types, codes and helpers shared by the slot free list allocator
// ----------------------------------------------------------------------------
package sfla_pkg;

  // field widths
  localparam int IDX_W    = 10;
  localparam int OFF_W    = 18;
  localparam int SIZE_W   = 9;
  localparam int COUNT_W  = 11;
  localparam int FRESH_W  = 11;
  localparam int APB_DW   = 32;
  localparam int CFG_AW   = 3;

  // reach of the index field and default stack depth
  localparam int INDEX_REACH   = 1024;
  localparam int MAX_SLOTS_DEF = 1024;

  // register reset values
  localparam logic [SIZE_W-1:0]  SLOT_BYTES_RST = SIZE_W'(64);
  localparam logic [COUNT_W-1:0] SLOT_COUNT_RST = COUNT_W'(1024);
  localparam logic [SIZE_W-1:0]  SLOT_BYTES_MAX = SIZE_W'(256);

  // register indexes
  localparam logic REG_SLOT_BYTES = 1'b0;
  localparam logic REG_SLOT_COUNT = 1'b1;

  // opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_SLOT    = 2'd1,
    ST_STACK_FULL = 2'd2
  } sfla_status_t;

  typedef struct packed {
    logic             opcode;
    logic [IDX_W-1:0] free_slot;
  } sfla_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]  slot_index;
    logic [OFF_W-1:0]  byte_offset;
    logic [SIZE_W-1:0] slot_size;
    sfla_status_t      status;
  } sfla_out_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  slot_bytes;
    logic [COUNT_W-1:0] slot_count;
  } sfla_cfg_t;

  // zero acts as one, anything above 256 acts as 256
  function automatic logic [SIZE_W-1:0] clamp_bytes(input logic [SIZE_W-1:0] b);
    logic [SIZE_W-1:0] r;
    r = b;
    if (b == '0) begin
      r = SIZE_W'(1);
    end else if (b > SLOT_BYTES_MAX) begin
      r = SLOT_BYTES_MAX;
    end
    return r;
  endfunction

endpackage

>>> hdl/sfla_ram.sv
// ----------------------------------------------------------------------------
// sfla_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module sfla_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sfla_cfg.sv
// ----------------------------------------------------------------------------
// sfla_cfg
// apb register file holding slot size and slot count
// ----------------------------------------------------------------------------
module sfla_cfg
  import sfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output sfla_cfg_t         cfg
);

  logic [SIZE_W-1:0]  slot_bytes_r;
  logic [COUNT_W-1:0] slot_count_r;
  logic               wr_en;
  logic               reg_sel;

  // register index is the word address
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite & pready;
  assign pready  = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_bytes_r <= SLOT_BYTES_RST;
      slot_count_r <= SLOT_COUNT_RST;
    end else if (wr_en) begin
      if (reg_sel == REG_SLOT_BYTES) begin
        slot_bytes_r <= pwdata[SIZE_W-1:0];
      end else begin
        slot_count_r <= pwdata[COUNT_W-1:0];
      end
    end
  end

  // read mux
  always_comb begin
    if (reg_sel == REG_SLOT_COUNT) begin
      prdata = APB_DW'(slot_count_r);
    end else begin
      prdata = APB_DW'(slot_bytes_r);
    end
  end

  assign cfg.slot_bytes = slot_bytes_r;
  assign cfg.slot_count = slot_count_r;

endmodule

>>> hdl/sfla_ctrl.sv
// ----------------------------------------------------------------------------
// sfla_ctrl
// transaction sequencer: pops or pushes the free stack ram, runs the bump
// counter and forms the result
// ----------------------------------------------------------------------------
module sfla_ctrl
  import sfla_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  sfla_in_t  in_data,
  output logic      out_valid,
  output sfla_out_t out_data,
  input  sfla_cfg_t cfg
);

  localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W    = $clog2(MAX_SLOTS);
  localparam int FRESH_CAP = (MAX_SLOTS < INDEX_REACH) ? MAX_SLOTS : INDEX_REACH;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t             state_r;
  sfla_in_t           req_r;
  logic [DEPTH_W-1:0] depth_r, depth_nxt, depth_dec;
  logic [FRESH_W-1:0] fresh_r, fresh_nxt, fresh_lim;
  logic               out_valid_r;
  sfla_out_t          out_data_r, out_data_nxt;
  logic               accept;

  // stack ram ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [IDX_W-1:0]  ram_rdata;

  // result datapath
  logic                     granted;
  logic [IDX_W-1:0]         grant_idx;
  logic [SIZE_W-1:0]        eff_bytes;
  logic [OFF_W-1:0]         product;

  assign accept = start & (state_r == S_IDLE);
  assign busy   = (state_r == S_EXEC);

  // stack top is read every cycle; valid in the cycle after accept
  assign depth_dec = depth_r - DEPTH_W'(1);
  assign ram_raddr = depth_dec[ADDR_W-1:0];
  assign ram_waddr = depth_r[ADDR_W-1:0];

  sfla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_r.free_slot),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // fresh slot limit: smallest of count, stack depth and index reach
  assign fresh_lim = (cfg.slot_count > COUNT_W'(FRESH_CAP)) ? FRESH_W'(FRESH_CAP)
                                                           : cfg.slot_count;
  assign eff_bytes = clamp_bytes(cfg.slot_bytes);

  // pop, bump or push
  always_comb begin
    depth_nxt = depth_r;
    fresh_nxt = fresh_r;
    ram_we    = 1'b0;
    granted   = 1'b0;
    grant_idx = '0;
    out_data_nxt = '{slot_index: '0, byte_offset: '0, slot_size: '0, status: ST_OK};
    if (state_r == S_EXEC) begin
      if (req_r.opcode == OP_ALLOC) begin
        priority if (depth_r != '0) begin
          depth_nxt = depth_dec;
          grant_idx = ram_rdata;
          granted   = 1'b1;
        end else if (fresh_r < fresh_lim) begin
          fresh_nxt = fresh_r + FRESH_W'(1);
          grant_idx = fresh_r[IDX_W-1:0];
          granted   = 1'b1;
        end else begin
          out_data_nxt.status = ST_NO_SLOT;
        end
      end else begin
        if (depth_r < DEPTH_W'(MAX_SLOTS)) begin
          ram_we    = 1'b1;
          depth_nxt = depth_r + DEPTH_W'(1);
        end else begin
          out_data_nxt.status = ST_STACK_FULL;
        end
      end
    end
    // largest product is 256 * 1023, which fits the offset field
    product = OFF_W'(eff_bytes) * OFF_W'(grant_idx);
    if (granted) begin
      out_data_nxt.slot_index  = grant_idx;
      out_data_nxt.slot_size   = eff_bytes;
      out_data_nxt.byte_offset = product;
    end
  end

  // state, counters and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      fresh_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      depth_r     <= depth_nxt;
      fresh_r     <= fresh_nxt;
      out_valid_r <= (state_r == S_EXEC);
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
            req_r   <= in_data;
          end
        end
        S_EXEC: begin
          state_r    <= S_IDLE;
          out_data_r <= out_data_nxt;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/slot_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// slot_free_list_allocator_top
// fixed-size slot allocator: lifo stack of freed indices backed by a bump
// counter, results give index, byte offset and slot size
// ----------------------------------------------------------------------------
// channel   ports                          handshake
// input     start, busy, in_data           taken when start & !busy
// result    out_valid, out_data            one-cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr,  apb write in access phase,
//           pwdata, prdata, pready         pready tied high
//
// each transaction first does the registered read of the stack top from the
// stack ram, then updates the stack or bump counter and registers the
// result; the strobe shows in the cycle after that.
// a new transaction can be started in the cycle the previous result shows.
// reset (rst_n, synchronous) empties the stack and zeroes the bump counter;
// the stack ram itself is not cleared and needs no clearing pass.
// results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
`include "slot_free_list_allocator_top_macros.svh"

module slot_free_list_allocator_top
  import sfla_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              start,
  output logic              busy,
  input  sfla_in_t          in_data,
  // result channel
  output logic              out_valid,
  output sfla_out_t         out_data,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  sfla_cfg_t cfg;
  logic      out_grant_zero;

  // configuration registers
  sfla_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // allocator sequencer with stack ram
  sfla_ctrl #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg       (cfg)
  );

  // result carries no grant
  assign out_grant_zero = (out_data.slot_index == '0) && (out_data.slot_size == '0) &&
                          (out_data.byte_offset == '0);

  // every accepted transaction yields its result strobe
  `SFLA_ASSERT_LAT2(a_accept_to_result, start && !busy, out_valid)
  // results never come back to back
  `SFLA_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  // the result cycle is an idle cycle
  `SFLA_ASSERT_IMPL(a_strobe_idle, out_valid, !busy)
  // a failed transaction grants nothing
  `SFLA_ASSERT_IMPL(a_fail_zero, out_valid && out_data.status != ST_OK, out_grant_zero)

endmodule
